FILE: src/srlb_pkg.sv
// Shared constants, types and helpers for the shade ramp builder.
package srlb_pkg;

  localparam int unsigned DefShadeDepth = 32;
  localparam int unsigned DefMaxColors  = 32;

  localparam logic [16:0] OneQ16 = 17'h10000;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegAmbient  = 3'd0;
  localparam logic [2:0] RegSpecPow  = 3'd1;
  localparam logic [2:0] RegSpecEn   = 3'd2;
  localparam logic [2:0] RegBackFade = 3'd3;
  localparam logic [2:0] RegBackRgb  = 3'd4;

  // Status codes of a result.
  localparam logic [1:0] StatNew  = 2'd0;
  localparam logic [1:0] StatHit  = 2'd1;
  localparam logic [1:0] StatFull = 2'd2;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LEVEL,
    OP_INTEN,
    OP_POW_INIT,
    OP_POW_STEP,
    OP_SPEC,
    OP_CHAN_MUL,
    OP_CHAN_OUT
  } srlb_op_e;

  typedef struct packed {
    srlb_op_e   op;
    logic [1:0] chan;
  } srlb_cmd_t;

  typedef struct packed {
    logic lvl_done;
  } srlb_sts_t;

endpackage

FILE: src/srlb_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module srlb_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 32
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write and read, read data registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: src/srlb_datapath.sv
// Shade arithmetic datapath: level fraction, intensity, power and channel blends.
module srlb_datapath
  import srlb_pkg::*;
#(
  parameter int unsigned ShadeDepth = DefShadeDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  srlb_cmd_t   cmd_i,
  input  logic [6:0]  level_i,
  input  logic [15:0] ambient_i,
  input  logic        spec_en_i,
  input  logic        fade_en_i,
  input  logic [23:0] color_i,
  input  logic [23:0] back_i,
  output srlb_sts_t   sts_o,
  output logic [23:0] shade_o
);
  // Level fraction i*65536/(depth-1) kept as quotient and remainder, so each
  // level adds a constant step and carries one when the remainder wraps.
  localparam logic [6:0]  StepDiv = 7'(ShadeDepth - 1);
  localparam logic [16:0] StepQuo = 17'(32'd65536 / (ShadeDepth - 1));
  localparam logic [6:0]  StepRem = 7'(32'd65536 % (ShadeDepth - 1));

  logic            lbusy_q, lbusy_d;
  logic [16:0]     tacc_q, tacc_d;
  logic [6:0]      trem_q, trem_d, rem_sum;
  logic [16:0]     t_q, t_d, p_q, p_d, inten_q, inten_d, fade_q, fade_d;
  logic [7:0]      k_q, k_d;
  logic [24:0]     acc_q, acc_d;
  logic [23:0]     shade_q, shade_d;
  logic [33:0]     prod_a;
  logic [24:0]     prod_b;
  logic [16:0]     mul_x, mul_y;
  logic [7:0]      c_sel, b_sel;
  logic [9:0]      vsum;

  // Shared Q1.16 multiplier.
  assign prod_a = mul_x * mul_y;

  always_comb begin
    case (cmd_i.chan)
      2'd0:    begin c_sel = color_i[23:16]; b_sel = back_i[23:16]; end
      2'd1:    begin c_sel = color_i[15:8];  b_sel = back_i[15:8];  end
      default: begin c_sel = color_i[7:0];   b_sel = back_i[7:0];   end
    endcase
  end

  always_comb begin
    lbusy_d = lbusy_q; tacc_d = tacc_q; trem_d = trem_q;
    t_d = t_q; p_d = p_q; inten_d = inten_q; fade_d = fade_q;
    k_d = k_q; acc_d = acc_q; shade_d = shade_q;
    mul_x = 17'd0; mul_y = 17'd0;
    prod_b = 25'd0;
    rem_sum = '0;
    vsum = '0;
    // Advance the level fraction (clear it at level zero) the cycle after the level command.
    if (lbusy_q) begin
      lbusy_d = 1'b0;
      if (level_i == 7'd0) begin
        tacc_d = '0;
        trem_d = '0;
      end else begin
        rem_sum = trem_q + StepRem;
        if (rem_sum >= StepDiv) begin
          trem_d = rem_sum - StepDiv;
          tacc_d = tacc_q + StepQuo + 17'd1;
        end else begin
          trem_d = rem_sum;
          tacc_d = tacc_q + StepQuo;
        end
      end
    end
    case (cmd_i.op)
      OP_LEVEL: lbusy_d = 1'b1;
      OP_INTEN: begin
        t_d = tacc_q;
        mul_x = OneQ16 - {1'b0, ambient_i};
        mul_y = tacc_q;
        inten_d = 17'(prod_a[33:16]) + {1'b0, ambient_i};
        fade_d = OneQ16 - inten_d;
        k_d = 8'd0;
      end
      OP_POW_INIT: p_d = t_q;
      OP_POW_STEP: begin
        mul_x = p_q; mul_y = t_q;
        p_d = prod_a[32:16];
      end
      OP_SPEC: begin
        k_d = 8'((25'd255 * {8'd0, p_q}) >> 16);
        mul_x = inten_q; mul_y = OneQ16 - p_q;
        inten_d = prod_a[32:16];
      end
      OP_CHAN_MUL: begin
        mul_x = {9'd0, c_sel}; mul_y = inten_q;
        acc_d = prod_a[24:0];
        if (spec_en_i && cmd_i.chan == 2'd3) begin
          mul_x = fade_q; mul_y = OneQ16 - p_q;
          fade_d = prod_a[32:16];
          acc_d = acc_q;
        end
      end
      OP_CHAN_OUT: begin
        prod_b = fade_en_i ? 25'(fade_q * b_sel) : 25'd0;
        vsum = 10'((acc_q + prod_b) >> 16) + (spec_en_i ? {2'd0, k_q} : 10'd0);
        case (cmd_i.chan)
          2'd0:    shade_d[23:16] = vsum > 10'd255 ? 8'hFF : vsum[7:0];
          2'd1:    shade_d[15:8]  = vsum > 10'd255 ? 8'hFF : vsum[7:0];
          default: shade_d[7:0]   = vsum > 10'd255 ? 8'hFF : vsum[7:0];
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lbusy_q <= 1'b0;
    end else begin
      lbusy_q <= lbusy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tacc_q <= tacc_d; trem_q <= trem_d; t_q <= t_d; p_q <= p_d;
    inten_q <= inten_d; fade_q <= fade_d; k_q <= k_d;
    acc_q <= acc_d; shade_q <= shade_d;
  end

  assign sts_o.lvl_done = !lbusy_q;
  assign shade_o = shade_q;
endmodule

FILE: src/srlb_ctrl.sv
// Controller: table search, registration and per-level shade sequencing.
module srlb_ctrl
  import srlb_pkg::*;
#(
  parameter int unsigned ShadeDepth = DefShadeDepth,
  parameter int unsigned MaxColors  = DefMaxColors
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [23:0] color_i,
  output logic [23:0] color_o,
  input  logic [6:0]  spec_pow_i,
  input  logic        spec_en_i,
  output srlb_cmd_t   cmd_o,
  input  srlb_sts_t   sts_i,
  output logic [6:0]  level_o,
  input  logic [23:0] shade_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [33:0] m_tdata_o,
  output logic [1:0]  m_tuser_o,
  output logic        m_tlast_o
);
  localparam int unsigned IdxW = (MaxColors > 1) ? $clog2(MaxColors) : 1;
  localparam int unsigned CntW = $clog2(MaxColors + 1);
  localparam int unsigned LvlW = $clog2(ShadeDepth);

  localparam logic [3:0] S_IDLE = 4'd0, S_READ = 4'd1, S_CMP = 4'd2,
    S_STEP = 4'd3, S_INTEN = 4'd4, S_PINIT = 4'd5, S_POW = 4'd6,
    S_SPEC = 4'd7, S_CMUL = 4'd8, S_COUT = 4'd9, S_EMIT = 4'd10,
    S_LEVEL = 4'd11;

  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d, scan_q, scan_d;
  logic [LvlW-1:0] lvl_q, lvl_d;
  logic [6:0]      pcnt_q, pcnt_d;
  logic [1:0]      chan_q, chan_d;
  logic [23:0]     color_q;
  logic [23:0]     rdata;
  logic [35:0]     out_q, out_d;
  logic            ovalid_q, ovalid_d, olast_q, olast_d;
  logic            we;
  srlb_cmd_t       cmd;

  srlb_ram #(.Width(24), .Depth(MaxColors)) u_ram (
    .clk_i, .we_i(we), .waddr_i(count_q[IdxW-1:0]), .wdata_i(color_q),
    .raddr_i(scan_q[IdxW-1:0]), .rdata_o(rdata)
  );

  assign s_tready_o = (state_q == S_IDLE) && !ovalid_q;

  always_comb begin
    state_d = state_q; count_d = count_q; scan_d = scan_q; lvl_d = lvl_q;
    pcnt_d = pcnt_q; chan_d = chan_q; out_d = out_q; ovalid_d = ovalid_q;
    olast_d = olast_q; we = 1'b0;
    cmd.op = OP_NONE; cmd.chan = chan_q;
    if (ovalid_q && m_tready_i) ovalid_d = 1'b0;
    case (state_q)
      S_IDLE: if (s_tvalid_i && s_tready_o) begin
        scan_d = '0; state_d = S_READ;
      end
      // Search registered colours one entry at a time.
      S_READ: begin
        if (scan_q >= count_q) begin
          if (count_q >= CntW'(MaxColors)) begin
            out_d = {24'd0, 10'd0, StatFull};
            ovalid_d = 1'b1; olast_d = 1'b1; state_d = S_IDLE;
          end else begin
            lvl_d = '0; state_d = S_LEVEL;
          end
        end else state_d = S_CMP;
      end
      S_CMP: begin
        if (rdata == color_q) begin
          out_d = {color_q, 10'(scan_q * ShadeDepth), StatHit};
          ovalid_d = 1'b1; olast_d = 1'b1; state_d = S_IDLE;
        end else begin
          scan_d = scan_q + 1'b1; state_d = S_READ;
        end
      end
      S_LEVEL: if (!ovalid_q || m_tready_i) begin
        cmd.op = OP_LEVEL; state_d = S_STEP;
      end
      S_STEP: if (sts_i.lvl_done) state_d = S_INTEN;
      S_INTEN: begin
        cmd.op = OP_INTEN; state_d = spec_en_i ? S_PINIT : S_CMUL;
        chan_d = 2'd0;
      end
      S_PINIT: begin
        cmd.op = OP_POW_INIT; pcnt_d = 7'd1; state_d = S_POW;
      end
      // Integer power by repeated multiply.
      S_POW: begin
        if (pcnt_q < spec_pow_i) begin
          cmd.op = OP_POW_STEP; pcnt_d = pcnt_q + 7'd1;
        end else begin
          chan_d = 2'd3; state_d = S_SPEC;
        end
      end
      S_SPEC: begin
        cmd.op = OP_SPEC; state_d = S_CMUL;
      end
      S_CMUL: begin
        cmd.op = OP_CHAN_MUL;
        if (chan_q == 2'd3) chan_d = 2'd0;
        else state_d = S_COUT;
      end
      S_COUT: begin
        cmd.op = OP_CHAN_OUT;
        if (chan_q == 2'd2) state_d = S_EMIT;
        else begin
          chan_d = chan_q + 2'd1; state_d = S_CMUL;
        end
      end
      S_EMIT: if (!ovalid_q || m_tready_i) begin
        out_d = {shade_i, 10'(count_q * ShadeDepth + lvl_q), StatNew};
        ovalid_d = 1'b1;
        olast_d = (lvl_q == LvlW'(ShadeDepth - 1));
        if (olast_d) begin
          we = 1'b1; count_d = count_q + 1'b1; state_d = S_IDLE;
        end else begin
          lvl_d = lvl_q + 1'b1; state_d = S_LEVEL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; count_q <= '0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; count_q <= count_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d; lvl_q <= lvl_d; pcnt_q <= pcnt_d; chan_q <= chan_d;
    out_q <= out_d; olast_q <= olast_d;
    if (s_tvalid_i && s_tready_o) color_q <= color_i;
  end

  assign color_o = color_q;
  assign cmd_o = cmd;
  assign level_o = 7'(lvl_q);
  assign m_tvalid_o = ovalid_q;
  assign m_tdata_o = out_q[35:2];
  assign m_tuser_o = out_q[1:0];
  assign m_tlast_o = olast_q;
endmodule

FILE: src/shade_ramp_lut_builder.sv
// Top level of the shade ramp builder: configuration registers and wiring.
//
// The slave stream takes one colour per request (tdata: red_in, green_in,
// blue_in from the lowest byte up). A colour already in the table gives one
// result with status 1 and its base address; a new colour with the table full
// gives one result with status 2. Any other colour gives SHADE_DEPTH results
// with status 0, one per level, the final one marked by tlast, and is stored.
// Status travels in m_tuser, lut_address and shade_rgb in m_tdata.
// The search reads and compares each registered colour in turn (RAM read,
// compare); a hit or a full table ends it, else the new colour starts its
// ramp. Each shade takes a level step, intensity, three multiply and blend
// pairs on one shared multiplier and the output register. With specular a
// shade adds the power init, one power step per unit of exponent above one,
// the specular step and a fade multiply. The next request is taken only
// once the last result has gone.
// Reset restores the register defaults and empties the colour table; no
// clearing pass is needed. When the receiver stalls the result register holds
// and the next shade waits until it is taken.
module shade_ramp_lut_builder
  import srlb_pkg::*;
#(
  parameter int unsigned SHADE_DEPTH = DefShadeDepth,
  parameter int unsigned MAX_COLORS  = DefMaxColors
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // lut_address, shade_rgb, 6 zero bits
  output logic [1:0]  m_tuser,   // status
  output logic        m_tlast,   // last_of_run
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);
  logic [15:0] ambient_q;
  logic [6:0]  spec_pow_q;
  logic        spec_en_q, fade_en_q;
  logic [23:0] back_q, color;
  logic [6:0]  level;
  logic [23:0] shade;
  logic [33:0] ctrl_data;
  srlb_cmd_t   cmd;
  srlb_sts_t   sts;

  // Write configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ambient_q <= 16'd26214; spec_pow_q <= 7'd8; spec_en_q <= 1'b0;
      fade_en_q <= 1'b0; back_q <= 24'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegAmbient:  ambient_q  <= cfg_data_i[15:0];
        RegSpecPow:  spec_pow_q <= cfg_data_i[6:0];
        RegSpecEn:   spec_en_q  <= cfg_data_i[0];
        RegBackFade: fade_en_q  <= cfg_data_i[0];
        RegBackRgb:  back_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  srlb_ctrl #(.ShadeDepth(SHADE_DEPTH), .MaxColors(MAX_COLORS)) u_ctrl (
    .clk_i, .rst_ni, .s_tvalid_i(s_tvalid), .s_tready_o(s_tready),
    .color_i({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]}), .color_o(color),
    .spec_pow_i(spec_pow_q), .spec_en_i(spec_en_q), .cmd_o(cmd), .sts_i(sts),
    .level_o(level), .shade_i(shade), .m_tvalid_o(m_tvalid),
    .m_tready_i(m_tready), .m_tdata_o(ctrl_data), .m_tuser_o(m_tuser),
    .m_tlast_o(m_tlast)
  );

  srlb_datapath #(.ShadeDepth(SHADE_DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .level_i(level), .ambient_i(ambient_q),
    .spec_en_i(spec_en_q), .fade_en_i(fade_en_q), .color_i(color),
    .back_i(back_q), .sts_o(sts), .shade_o(shade)
  );

  // Pack address and shade from the lowest bit up.
  assign m_tdata = {6'd0, ctrl_data};
endmodule

FILE: src/srlb_checker.sv
// Port-level checker for the shade ramp builder, bound to the top level.
module srlb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);
  // Hold a stalled result.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
    && $stable(m_tlast)) else $error("result dropped");
  // Take no request while a result waits.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> !s_tready) else $error("request taken while busy");
  // Hit and full results always close a run.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser != 2'd0 |-> m_tlast) else $error("run not closed");
  // Status code never three.
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> m_tuser != 2'd3) else $error("bad status");
endmodule

bind shade_ramp_lut_builder srlb_checker u_chk (
  .clk_i, .rst_ni, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser,
  .m_tlast
);
